### hdl/telnet_option_negotiation_parser_defines.svh
// ----------------------------------------------------------------------------
// telnet option negotiation parser: assertion macros
// shared assertion forms, included by tonp_queue alone of the parser modules
// ----------------------------------------------------------------------------
`ifndef TELNET_OPTION_NEGOTIATION_PARSER_DEFINES_SVH
`define TELNET_OPTION_NEGOTIATION_PARSER_DEFINES_SVH

// condition holds at every edge out of reset
`define TONP_ASSERT_ALWAYS(name, clk_s, rstn_s, expr) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (expr)) \
        else $error("tonp assertion failed");

// same-cycle implication
`define TONP_ASSERT_IMPLY(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("tonp implication failed");

// next-cycle implication
`define TONP_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("tonp next-cycle implication failed");

`endif

### hdl/tonp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tonp_pkg
// types, telnet codes and reply tables of the option negotiation parser
// ----------------------------------------------------------------------------
package tonp_pkg;

    localparam int SUB_BUFFER_BYTES_DEF = 16;
    localparam int QUEUE_DEPTH          = 4;
    localparam int OFFER_BEATS          = 27;
    localparam int IDX_W                = $clog2(OFFER_BEATS);

    // telnet command bytes
    localparam logic [7:0] T_IAC  = 8'd255;
    localparam logic [7:0] T_DONT = 8'd254;
    localparam logic [7:0] T_DO   = 8'd253;
    localparam logic [7:0] T_WONT = 8'd252;
    localparam logic [7:0] T_WILL = 8'd251;
    localparam logic [7:0] T_SB   = 8'd250;
    localparam logic [7:0] T_AYT  = 8'd246;
    localparam logic [7:0] T_NOP  = 8'd241;
    localparam logic [7:0] T_SE   = 8'd240;

    // option codes
    localparam logic [7:0] OPT_ECHO     = 8'd1;
    localparam logic [7:0] OPT_SGA      = 8'd3;
    localparam logic [7:0] OPT_TTYPE    = 8'd24;
    localparam logic [7:0] OPT_NAWS     = 8'd31;
    localparam logic [7:0] OPT_LINEMODE = 8'd34;
    localparam logic [7:0] OPT_ENVIRON  = 8'd39;
    localparam logic [7:0] TTYPE_SEND   = 8'd1;

    // result kinds
    localparam logic [1:0] OK_REPLY  = 2'd0;
    localparam logic [1:0] OK_DATA   = 2'd1;
    localparam logic [1:0] OK_WINDOW = 2'd2;

    // input kinds
    localparam logic IK_BYTE  = 1'b0;
    localparam logic IK_START = 1'b1;

    typedef enum logic [1:0] {
        PH_NORMAL,
        PH_IAC,
        PH_WILL,
        PH_DO
    } phase_t;

    typedef enum logic [2:0] {
        JOB_OFFER,
        JOB_DATA,
        JOB_NOP,
        JOB_TRIPLE,
        JOB_TTYPE,
        JOB_WINDOW
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  cmd;
        logic [7:0]  opt;
        logic [15:0] width;
        logic [15:0] height;
        logic        neg;
    } job_t;

    function automatic logic [7:0] will_answer(input logic [7:0] opt);
        if (opt == OPT_SGA || opt == OPT_TTYPE || opt == OPT_NAWS || opt == OPT_ENVIRON)
        begin
            return T_DO;
        end
        return T_DONT;
    endfunction

    function automatic logic [7:0] do_answer(input logic [7:0] opt);
        if (opt == OPT_ECHO || opt == OPT_SGA)
        begin
            return T_WILL;
        end
        return T_WONT;
    endfunction

    function automatic logic [7:0] offer_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24: b = T_IAC;
            5'd1:    b = T_WILL;
            5'd2:    b = OPT_ECHO;
            5'd4:    b = T_WILL;
            5'd5:    b = OPT_SGA;
            5'd7:    b = T_WONT;
            5'd8:    b = OPT_ENVIRON;
            5'd10:   b = T_DONT;
            5'd11:   b = OPT_ECHO;
            5'd13:   b = T_DO;
            5'd14:   b = OPT_SGA;
            5'd16:   b = T_DO;
            5'd17:   b = OPT_TTYPE;
            5'd19:   b = T_DO;
            5'd20:   b = OPT_NAWS;
            5'd22:   b = T_DONT;
            5'd23:   b = OPT_LINEMODE;
            5'd25:   b = T_DO;
            5'd26:   b = OPT_ENVIRON;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    // terminal type request after the reply triple
    function automatic logic [7:0] ttype_tail(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = T_IAC;
            3'd1:    b = T_SB;
            3'd2:    b = OPT_TTYPE;
            3'd3:    b = TTYPE_SEND;
            3'd4:    b = T_IAC;
            3'd5:    b = T_SE;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

### hdl/tonp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tonp_in_if
// received byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface tonp_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] in_byte;

    modport source (output valid, output kind, output in_byte, input ready);
    modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

### hdl/tonp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tonp_out_if
// result channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface tonp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [15:0] win_width;
    logic [15:0] win_height;
    logic        negotiated;
    logic        last;

    modport source (output valid, output out_kind, output out_byte, output win_width,
                    output win_height, output negotiated, output last, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input win_width,
                    input win_height, input negotiated, input last, output ready);
endinterface

### hdl/telnet_option_negotiation_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_option_negotiation_parser
// telnet IAC option negotiation: replies, passthrough bytes, window reports
// ----------------------------------------------------------------------------
// One received byte is accepted every cycle while the four-entry job queue
// has room; a byte that causes no result (IAC, command, sub-negotiation
// payload) only updates the parse state. Results leave at one beat per
// cycle while the receiver is ready, through a registered output stage: a
// data byte or window report is one beat, a NOP or AYT reply two, an option
// reply three, a WILL TTYPE reply nine and a session start 27, so the output
// port sets the sustained rate whenever replies are longer than one beat.
// ----------------------------------------------------------------------------
module telnet_option_negotiation_parser #(
    parameter int SUB_BUFFER_BYTES = tonp_pkg::SUB_BUFFER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tonp_in_if.sink     rx,
    tonp_out_if.source  tx
);
    import tonp_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    job_t push_job;
    job_t head;

    tonp_front #(
        .SUB_BUFFER_BYTES (SUB_BUFFER_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .q_full   (full),
        .push     (push),
        .push_job (push_job)
    );

    tonp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    tonp_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .tx    (tx)
    );

endmodule

### hdl/tonp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tonp_front
// accepts bytes, tracks the command phase and sub-negotiation, emits jobs
// ----------------------------------------------------------------------------
module tonp_front #(
    parameter int SUB_BUFFER_BYTES = tonp_pkg::SUB_BUFFER_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    tonp_in_if.sink         rx,
    input  logic            q_full,
    output logic            push,
    output tonp_pkg::job_t  push_job
);
    import tonp_pkg::*;

    localparam int CW = $clog2(SUB_BUFFER_BYTES);
    localparam logic [CW-1:0] CNT_MAX = CW'(SUB_BUFFER_BYTES - 1);
    localparam int KEPT = 5;

    phase_t        phase_reg, phase_next;
    logic          will_reg, will_next;
    logic          sub_reg, sub_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    store_reg [KEPT];
    logic [7:0]    store_next [KEPT];
    logic [1:0]    naws_reg, naws_next;
    logic          accept;
    logic [7:0]    b;
    job_t          job;
    logic          has_job;

    assign rx.ready = !q_full;
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.in_byte;

    always_comb
    begin
        phase_next = PH_NORMAL;
        if (rx.kind == IK_BYTE)
        begin
            case (phase_reg)
                PH_NORMAL: phase_next = (b == T_IAC) ? PH_IAC : PH_NORMAL;
                PH_IAC:
                begin
                    if (b == T_WILL || b == T_WONT)
                    begin
                        phase_next = PH_WILL;
                    end
                    else if (b == T_DO || b == T_DONT)
                    begin
                        phase_next = PH_DO;
                    end
                end
                default: phase_next = PH_NORMAL;
            endcase
        end
    end

    always_comb
    begin
        will_next  = will_reg;
        sub_next   = sub_reg;
        count_next = count_reg;
        store_next = store_reg;
        naws_next  = naws_reg;
        has_job    = 1'b0;
        job.kind   = JOB_DATA;
        job.cmd    = 8'd0;
        job.opt    = b;
        job.width  = 16'd0;
        job.height = 16'd0;
        if (rx.kind == IK_START)
        begin
            will_next  = 1'b0;
            sub_next   = 1'b0;
            count_next = '0;
            for (int i = 0; i < KEPT; i++)
            begin
                store_next[i] = 8'd0;
            end
            naws_next = 2'd0;
            has_job   = 1'b1;
            job.kind  = JOB_OFFER;
        end
        else
        begin
            case (phase_reg)
                PH_NORMAL:
                begin
                    if (b != T_IAC)
                    begin
                        if (sub_reg)
                        begin
                            if (count_reg < CNT_MAX)
                            begin
                                if (count_reg < CW'(KEPT))
                                begin
                                    store_next[count_reg[2:0]] = b;
                                end
                                count_next = count_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            has_job = 1'b1;
                        end
                    end
                end
                PH_IAC:
                begin
                    if (b == T_SE)
                    begin
                        sub_next = 1'b0;
                        if (store_reg[0] == OPT_NAWS)
                        begin
                            has_job    = 1'b1;
                            job.kind   = JOB_WINDOW;
                            job.width  = {store_reg[1], store_reg[2]};
                            job.height = {store_reg[3], store_reg[4]};
                            if (naws_reg != 2'd2)
                            begin
                                naws_next = naws_reg + 2'd1;
                            end
                        end
                    end
                    else if (b == T_NOP || b == T_AYT)
                    begin
                        has_job  = 1'b1;
                        job.kind = JOB_NOP;
                    end
                    else if (b == T_WILL || b == T_WONT)
                    begin
                        will_next = (b == T_WILL);
                    end
                    else if (b == T_SB)
                    begin
                        sub_next   = 1'b1;
                        count_next = '0;
                        for (int i = 0; i < KEPT; i++)
                        begin
                            store_next[i] = 8'd0;
                        end
                    end
                end
                PH_WILL:
                begin
                    has_job   = 1'b1;
                    job.cmd   = will_answer(b);
                    job.kind  = (will_reg && b == OPT_TTYPE) ? JOB_TTYPE : JOB_TRIPLE;
                    will_next = 1'b0;
                end
                default:
                begin
                    has_job  = 1'b1;
                    job.kind = JOB_TRIPLE;
                    job.cmd  = do_answer(b);
                end
            endcase
        end
        job.neg = (naws_next == 2'd2);
    end

    assign push     = accept && has_job;
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NORMAL;
            will_reg  <= 1'b0;
            sub_reg   <= 1'b0;
            count_reg <= '0;
            naws_reg  <= 2'd0;
            for (int i = 0; i < KEPT; i++)
            begin
                store_reg[i] <= 8'd0;
            end
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            will_reg  <= will_next;
            sub_reg   <= sub_next;
            count_reg <= count_next;
            naws_reg  <= naws_next;
            store_reg <= store_next;
        end
    end

endmodule

### hdl/tonp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tonp_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
`include "telnet_option_negotiation_parser_defines.svh"

module tonp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tonp_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output tonp_pkg::job_t  head,
    output logic            empty
);
    import tonp_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    job_t           mem [QUEUE_DEPTH];
    logic [QAW-1:0] wr_reg;
    logic [QAW-1:0] rd_reg;
    logic [QCW-1:0] count_reg, count_next;

    assign full  = (count_reg == QCW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `TONP_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= QCW'(QUEUE_DEPTH))
    `TONP_ASSERT_IMPLY(a_no_push_full, clk, rst_n, push, !full)
    `TONP_ASSERT_IMPLY(a_no_pop_empty, clk, rst_n, pop, !empty)
    `TONP_ASSERT_NEXT(a_fill_step, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

### hdl/tonp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tonp_back
// expands queued jobs into result beats behind an output register
// ----------------------------------------------------------------------------
module tonp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  tonp_pkg::job_t  head,
    input  logic            empty,
    output logic            pop,
    tonp_out_if.source      tx
);
    import tonp_pkg::*;

    localparam logic [IDX_W-1:0] OFFER_LAST = IDX_W'(OFFER_BEATS - 1);

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] tail_idx;
    logic             valid_reg;
    logic [1:0]       kind_reg;
    logic [7:0]       byte_reg;
    logic [15:0]      width_reg;
    logic [15:0]      height_reg;
    logic             neg_reg;
    logic             last_reg;
    logic             load;
    logic [1:0]       beat_kind;
    logic [7:0]       beat_byte;
    logic             beat_last;
    logic [7:0]       triple_byte;

    assign tail_idx = idx_reg - IDX_W'(3);

    always_comb
    begin
        case (idx_reg)
            IDX_W'(0): triple_byte = T_IAC;
            IDX_W'(1): triple_byte = head.cmd;
            default:   triple_byte = head.opt;
        endcase
    end

    always_comb
    begin
        beat_kind = OK_REPLY;
        beat_byte = 8'd0;
        beat_last = 1'b1;
        case (head.kind)
            JOB_OFFER:
            begin
                beat_byte = offer_byte(idx_reg);
                beat_last = (idx_reg == OFFER_LAST);
            end
            JOB_DATA:
            begin
                beat_kind = OK_DATA;
                beat_byte = head.opt;
            end
            JOB_NOP:
            begin
                beat_byte = (idx_reg == '0) ? T_IAC : T_NOP;
                beat_last = (idx_reg == IDX_W'(1));
            end
            JOB_TRIPLE:
            begin
                beat_byte = triple_byte;
                beat_last = (idx_reg == IDX_W'(2));
            end
            JOB_TTYPE:
            begin
                beat_byte = (idx_reg < IDX_W'(3)) ? triple_byte : ttype_tail(tail_idx[2:0]);
                beat_last = (idx_reg == IDX_W'(8));
            end
            JOB_WINDOW:
            begin
                beat_kind = OK_WINDOW;
            end
            default:
            begin
                beat_last = 1'b1;
            end
        endcase
    end

    assign load = !empty && (!valid_reg || tx.ready);
    assign pop  = load && beat_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= beat_last ? '0 : idx_reg + 1'b1;
            end
            else if (tx.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= beat_kind;
            byte_reg   <= beat_byte;
            width_reg  <= (head.kind == JOB_WINDOW) ? head.width : 16'd0;
            height_reg <= (head.kind == JOB_WINDOW) ? head.height : 16'd0;
            neg_reg    <= head.neg;
            last_reg   <= beat_last;
        end
    end

    assign tx.valid      = valid_reg;
    assign tx.out_kind   = kind_reg;
    assign tx.out_byte   = byte_reg;
    assign tx.win_width  = width_reg;
    assign tx.win_height = height_reg;
    assign tx.negotiated = neg_reg;
    assign tx.last       = last_reg;

endmodule

### sim/telnet_option_negotiation_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_option_negotiation_parser_tb
// Self-checking bench for the telnet option negotiation parser. A scoreboard
// predicts the reply, passthrough and window report beats for every accepted
// input beat and checks the result channel in order, field by field. A short
// directed sequence is followed by random telnet traffic: data, NOP and AYT,
// option commands, NAWS and other sub-negotiations, session starts and broken
// sequences. Both handshake sides idle at random, and one long receiver
// hold-off makes the parser fill up and stall its input.
// ----------------------------------------------------------------------------
module telnet_option_negotiation_parser_tb;
    import tonp_pkg::*;

    localparam int SUB_BYTES    = SUB_BUFFER_BYTES_DEF;
    localparam int RANDOM_BEATS = 430;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 32;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [7:0] OFFER_SEQ [OFFER_BEATS] = '{
        T_IAC, T_WILL, OPT_ECHO,    T_IAC, T_WILL, OPT_SGA,      T_IAC, T_WONT, OPT_ENVIRON,
        T_IAC, T_DONT, OPT_ECHO,    T_IAC, T_DO,   OPT_SGA,      T_IAC, T_DO,   OPT_TTYPE,
        T_IAC, T_DO,   OPT_NAWS,    T_IAC, T_DONT, OPT_LINEMODE, T_IAC, T_DO,   OPT_ENVIRON
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  val;
        logic [15:0] width;
        logic [15:0] height;
        logic        neg;
        logic        last;
    } beat_t;

    class reply_scoreboard;
        beat_t      pending[$];
        beat_t      burst[$];
        phase_t     phase;
        bit         will_seen;
        bit         sub_active;
        logic [7:0] sub_store [SUB_BYTES];
        int         sub_count;
        int         naws_seen;
        int         mismatches;
        int         inputs_seen;
        int         results_seen;
        int         window_reports;
        int         sessions;

        function new();
            clear_session();
        endfunction

        function void clear_session();
            phase      = PH_NORMAL;
            will_seen  = 1'b0;
            sub_active = 1'b0;
            sub_count  = 0;
            naws_seen  = 0;
            foreach (sub_store[i])
            begin
                sub_store[i] = '0;
            end
        endfunction

        function void add_beat(logic [1:0] k, logic [7:0] v, logic [15:0] w, logic [15:0] h);
            beat_t bt;
            bt.kind   = k;
            bt.val    = v;
            bt.width  = w;
            bt.height = h;
            bt.neg    = 1'b0;
            bt.last   = 1'b0;
            burst.push_back(bt);
        endfunction

        function void add_triple(logic [7:0] cmd, logic [7:0] opt);
            add_beat(OK_REPLY, T_IAC, '0, '0);
            add_beat(OK_REPLY, cmd, '0, '0);
            add_beat(OK_REPLY, opt, '0, '0);
        endfunction

        function void predict_replies(logic k, logic [7:0] b);
            logic [7:0] answer;
            burst.delete();
            inputs_seen++;
            if (k == IK_START)
            begin
                sessions++;
                clear_session();
                foreach (OFFER_SEQ[i])
                begin
                    add_beat(OK_REPLY, OFFER_SEQ[i], '0, '0);
                end
            end
            else
            begin
                case (phase)
                    PH_NORMAL:
                    begin
                        if (b == T_IAC)
                        begin
                            phase = PH_IAC;
                        end
                        else if (sub_active)
                        begin
                            if (sub_count < SUB_BYTES - 1)
                            begin
                                sub_store[sub_count] = b;
                                sub_count++;
                            end
                        end
                        else
                        begin
                            add_beat(OK_DATA, b, '0, '0);
                        end
                    end
                    PH_IAC:
                    begin
                        phase = PH_NORMAL;
                        if (b == T_SE)
                        begin
                            sub_active = 1'b0;
                            if (sub_store[0] == OPT_NAWS)
                            begin
                                if (naws_seen < 2)
                                begin
                                    naws_seen++;
                                end
                                add_beat(OK_WINDOW, '0, {sub_store[1], sub_store[2]},
                                         {sub_store[3], sub_store[4]});
                            end
                        end
                        else if (b == T_NOP || b == T_AYT)
                        begin
                            add_beat(OK_REPLY, T_IAC, '0, '0);
                            add_beat(OK_REPLY, T_NOP, '0, '0);
                        end
                        else if (b == T_WILL || b == T_WONT)
                        begin
                            phase     = PH_WILL;
                            will_seen = (b == T_WILL);
                        end
                        else if (b == T_DO || b == T_DONT)
                        begin
                            phase = PH_DO;
                        end
                        else if (b == T_SB)
                        begin
                            sub_active = 1'b1;
                            sub_count  = 0;
                            foreach (sub_store[i])
                            begin
                                sub_store[i] = '0;
                            end
                        end
                    end
                    PH_WILL:
                    begin
                        phase = PH_NORMAL;
                        if (b == OPT_SGA || b == OPT_TTYPE || b == OPT_NAWS || b == OPT_ENVIRON)
                        begin
                            answer = T_DO;
                        end
                        else
                        begin
                            answer = T_DONT;
                        end
                        add_triple(answer, b);
                        if (will_seen && b == OPT_TTYPE)
                        begin
                            add_triple(T_SB, OPT_TTYPE);
                            add_beat(OK_REPLY, TTYPE_SEND, '0, '0);
                            add_beat(OK_REPLY, T_IAC, '0, '0);
                            add_beat(OK_REPLY, T_SE, '0, '0);
                        end
                        will_seen = 1'b0;
                    end
                    default:
                    begin
                        phase = PH_NORMAL;
                        if (b == OPT_ECHO || b == OPT_SGA)
                        begin
                            answer = T_WILL;
                        end
                        else
                        begin
                            answer = T_WONT;
                        end
                        add_triple(answer, b);
                    end
                endcase
            end
            foreach (burst[i])
            begin
                burst[i].neg  = (naws_seen >= 2);
                burst[i].last = (i == burst.size() - 1);
                pending.push_back(burst[i]);
            end
        endfunction

        task report(string msg);
            mismatches++;
            $display("ERROR beat %0d: %s", results_seen, msg);
        endtask

        task check_beat(beat_t got);
            beat_t want;
            results_seen++;
            if (got.kind == OK_WINDOW)
            begin
                window_reports++;
            end
            if (pending.size() == 0)
            begin
                report("result beat with nothing expected");
            end
            else
            begin
                want = pending.pop_front();
                if (got.kind !== want.kind)
                    report($sformatf("out_kind %0d, want %0d", got.kind, want.kind));
                if (got.val !== want.val)
                    report($sformatf("out_byte %0d, want %0d", got.val, want.val));
                if (got.width !== want.width)
                    report($sformatf("win_width %0d, want %0d", got.width, want.width));
                if (got.height !== want.height)
                    report($sformatf("win_height %0d, want %0d", got.height, want.height));
                if (got.neg !== want.neg)
                    report($sformatf("negotiated %0b, want %0b", got.neg, want.neg));
                if (got.last !== want.last)
                    report($sformatf("last %0b, want %0b", got.last, want.last));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   sent_beats;
    bit   no_idle;
    bit   hold_request;
    bit   hold_done;
    beat_t seen_beat;

    reply_scoreboard sb = new();

    tonp_in_if  rx_if ();
    tonp_out_if tx_if ();

    telnet_option_negotiation_parser u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .tx    (tx_if)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d beats outstanding", cycle_count, sb.pending.size());
        $display("telnet_option_negotiation_parser_tb failed");
        $finish;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && tx_if.valid && tx_if.ready)
        begin
            seen_beat.kind   = tx_if.out_kind;
            seen_beat.val    = tx_if.out_byte;
            seen_beat.width  = tx_if.win_width;
            seen_beat.height = tx_if.win_height;
            seen_beat.neg    = tx_if.negotiated;
            seen_beat.last   = tx_if.last;
            sb.check_beat(seen_beat);
        end
    end

    // receiver with random stalls and one long hold-off
    initial
    begin
        int hold_left;
        hold_left   = 0;
        tx_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                tx_if.ready = 1'b0;
            end
            else
            begin
                tx_if.ready = no_idle || ($urandom_range(0, 99) >= 36);
            end
        end
    end

    task automatic send_item(input logic k, input logic [7:0] b);
        while (!no_idle && $urandom_range(0, 99) < 36)
        begin
            rx_if.valid   = 1'b0;
            rx_if.kind    = 1'($urandom_range(0, 1));
            rx_if.in_byte = 8'($urandom_range(0, 255));
            @(negedge clk);
        end
        rx_if.valid   = 1'b1;
        rx_if.kind    = k;
        rx_if.in_byte = b;
        do
        begin
            @(posedge clk);
        end
        while (!rx_if.ready);
        sb.predict_replies(k, b);
        sent_beats++;
        @(negedge clk);
    endtask

    task automatic send_option(input logic [7:0] cmd, input logic [7:0] opt);
        send_item(IK_BYTE, T_IAC);
        send_item(IK_BYTE, cmd);
        send_item(IK_BYTE, opt);
    endtask

    task automatic send_naws(input logic [15:0] w, input logic [15:0] h);
        send_item(IK_BYTE, T_IAC);
        send_item(IK_BYTE, T_SB);
        send_item(IK_BYTE, OPT_NAWS);
        send_item(IK_BYTE, w[15:8]);
        send_item(IK_BYTE, w[7:0]);
        send_item(IK_BYTE, h[15:8]);
        send_item(IK_BYTE, h[7:0]);
        send_item(IK_BYTE, T_IAC);
        send_item(IK_BYTE, T_SE);
    endtask

    // payload bytes stay below IAC so that none is taken as a command
    function automatic logic [7:0] plain_byte();
        return 8'($urandom_range(0, 254));
    endfunction

    function automatic logic [7:0] pick_option();
        logic [7:0] opts [7];
        opts = '{OPT_ECHO, OPT_SGA, OPT_TTYPE, OPT_NAWS, OPT_LINEMODE, OPT_ENVIRON, 8'd0};
        if ($urandom_range(0, 1) == 0)
        begin
            return opts[$urandom_range(0, 6)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_sequence();
        int         pick;
        int         len;
        logic [7:0] cmds [4];
        cmds = '{T_WILL, T_WONT, T_DO, T_DONT};
        pick = $urandom_range(0, 99);
        if (pick < 28)
        begin
            repeat ($urandom_range(1, 4))
            begin
                send_item(IK_BYTE, plain_byte());
            end
        end
        else if (pick < 40)
        begin
            send_item(IK_BYTE, T_IAC);
            send_item(IK_BYTE, ($urandom_range(0, 1) == 0) ? T_NOP : T_AYT);
        end
        else if (pick < 68)
        begin
            send_option(cmds[$urandom_range(0, 3)], pick_option());
        end
        else if (pick < 82)
        begin
            send_naws(16'($urandom_range(0, 16'hfefe)), 16'($urandom_range(0, 16'hfefe)));
        end
        else if (pick < 90)
        begin
            // other or oversized sub-negotiation, sometimes with an escaped IAC
            len = $urandom_range(0, 20);
            send_item(IK_BYTE, T_IAC);
            send_item(IK_BYTE, T_SB);
            repeat (len)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_item(IK_BYTE, T_IAC);
                    send_item(IK_BYTE, T_IAC);
                end
                else
                begin
                    send_item(IK_BYTE, plain_byte());
                end
            end
            send_item(IK_BYTE, T_IAC);
            send_item(IK_BYTE, T_SE);
        end
        else if (pick < 92)
        begin
            send_item(IK_START, 8'($urandom_range(0, 255)));
        end
        else if (pick < 96)
        begin
            send_item(IK_BYTE, T_IAC);
            send_item(IK_BYTE, 8'($urandom_range(0, 255)));
        end
        else
        begin
            send_item(IK_BYTE, 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int target;
        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.kind    = IK_BYTE;
        rx_if.in_byte = '0;
        no_idle       = 1'b0;
        hold_request  = 1'b0;
        sent_beats    = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_item(IK_START, 8'h00);
        send_item(IK_BYTE, 8'h00);
        send_item(IK_BYTE, 8'h7f);
        send_item(IK_BYTE, T_IAC);
        send_item(IK_BYTE, T_IAC);
        send_item(IK_BYTE, T_IAC);
        send_item(IK_BYTE, T_NOP);
        send_item(IK_BYTE, T_IAC);
        send_item(IK_BYTE, T_AYT);
        send_option(T_WILL, OPT_TTYPE);
        send_option(T_DONT, OPT_ECHO);
        send_item(IK_BYTE, T_IAC);
        send_item(IK_BYTE, 8'h10);
        send_item(IK_BYTE, T_IAC);
        send_item(IK_BYTE, T_SE);
        send_naws(16'd80, 16'd24);

        target       = sent_beats + RANDOM_BEATS;
        hold_request = 1'b1;
        while (sent_beats < target)
        begin
            no_idle = (sent_beats > target - 280) && (sent_beats < target - 180);
            random_sequence();
        end
        no_idle     = 1'b0;
        rx_if.valid = 1'b0;

        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input beats, %0d session starts, %0d result beats, %0d window reports",
                 sb.inputs_seen, sb.sessions, sb.results_seen, sb.window_reports);
        $display("%0d mismatches after %0d cycles", sb.mismatches, cycle_count);
        if (sb.mismatches == 0)
        begin
            $display("telnet_option_negotiation_parser_tb passed");
        end
        else
        begin
            $display("telnet_option_negotiation_parser_tb failed");
        end
        $finish;
    end

endmodule
